FILE: hdl/bst_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the bounded set table.
// Depends on nothing; the cell and the top level import it.
package bst_pkg;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_QUERY  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_PRESENT = 2'd2,
    ST_ABSENT  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC,
    S_SHIFT
  } state_t;

  // Controls broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic cmp_en;
    logic set_hole;
    logic step;
  } cell_ctrl_t;

  localparam int CountWidth = 5;
  localparam int CfgWidth   = 5;
  localparam int KeyPortWidth = 32;

endpackage

FILE: hdl/bounded_set_table.sv
`timescale 1ns / 1ps
// Bounded set table: distinct keys in insertion order, held in a row of cells.
// Flow: a transaction is accepted, compared in the next cycle, then acted on in
// the execute state, which sets the registered result strobe; add and query then
// return to idle. A removal that finds its key then shifts: the hole walks up the
// row one cell per cycle while inside the occupied part. Reset (rst_n low,
// synchronous) empties the set and sets the capacity limit to 16; no result stalls.
module bounded_set_table #(
  parameter int DEPTH     = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Command channel.
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_func,
  input  logic [bst_pkg::KeyPortWidth-1:0]    in_key,
  // Result channel, one strobe per transaction.
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic                                out_found,
  output logic [bst_pkg::CountWidth-1:0]      out_count,
  // Configuration write channel for the capacity limit.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bst_pkg::CfgWidth-1:0]        cfg_capacity_limit
);
  import bst_pkg::*;

  // Width of the key count, which must be able to hold DEPTH itself.
  localparam int CW = $clog2(DEPTH + 1);
  // Width used for the capacity comparison, wide enough for both operands.
  localparam int LW = (CW > CfgWidth) ? CW : CfgWidth;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        held_r, held_nxt;
  logic [CfgWidth-1:0]  cap_r;
  logic [1:0]           func_r;
  logic [KEY_WIDTH-1:0] key_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic                 out_found_r, out_found_nxt;

  cell_ctrl_t           ctrl;
  logic                 wr_cell;
  logic [KEY_WIDTH-1:0] entry_vec [DEPTH];
  logic [DEPTH-1:0]     hole_vec;
  logic [DEPTH-1:0]     match_vec;
  logic [DEPTH-1:0]     valid_vec;
  logic [DEPTH-1:0]     wr_vec;

  logic                 hit;
  logic                 shifting;
  logic                 full;
  logic [LW-1:0]        limit;
  logic [LW-1:0]        cap_ext;
  logic [LW-1:0]        held_ext;
  logic [KEY_WIDTH+KeyPortWidth-1:0] key_wide;
  logic [CW+CountWidth-1:0]          count_wide;
  logic                 accept;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // Only the low KEY_WIDTH bits of the key port take part; a port narrower than
  // KEY_WIDTH is zero-extended.
  assign key_wide = (KEY_WIDTH + KeyPortWidth)'(in_key);

  // The effective limit is the configured one clamped to the row length.
  assign cap_ext  = LW'(cap_r);
  assign held_ext = LW'(held_r);
  assign limit    = (cap_ext > LW'(DEPTH)) ? LW'(DEPTH) : cap_ext;
  assign full     = (held_ext >= limit);

  // Keys are distinct, so at most one cell matches.
  assign hit      = |match_vec;
  // A hole still inside the occupied part of the row keeps the shift going.
  assign shifting = |(hole_vec & valid_vec);

  // Sequencer: accept, compare across the row, act, then walk any hole up.
  always_comb begin
    state_nxt      = state_r;
    held_nxt       = held_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    ctrl           = '0;
    wr_cell        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        out_valid_nxt = 1'b1;
        out_found_nxt = hit;
        state_nxt     = S_IDLE;
        case (func_r)
          FN_ADD: begin
            // The full test comes before the membership test.
            if (full) begin
              out_status_nxt = ST_FULL;
            end else if (hit) begin
              out_status_nxt = ST_PRESENT;
            end else begin
              out_status_nxt = ST_DONE;
              wr_cell        = 1'b1;
              held_nxt       = held_r + CW'(1);
            end
          end
          FN_REMOVE: begin
            if (!hit) begin
              out_status_nxt = ST_ABSENT;
            end else begin
              out_status_nxt = ST_DONE;
              ctrl.set_hole  = 1'b1;
              held_nxt       = held_r - CW'(1);
              state_nxt      = S_SHIFT;
            end
          end
          default: begin
            // Query, and the unused selector, which behaves as a query.
            out_status_nxt = hit ? ST_DONE : ST_ABSENT;
          end
        endcase
      end
      S_SHIFT: begin
        if (shifting) begin
          ctrl.step = 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      cap_r       <= CfgWidth'(16);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity_limit;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      key_r  <= key_wide[KEY_WIDTH-1:0];
    end
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
  end

  // The row of cells. Each cell knows whether it is occupied and whether it is
  // the next free place; entries beyond the count are never compared.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] next_entry;
    logic                 hole_in;

    assign valid_vec[i] = (CW'(i) < held_r);
    assign wr_vec[i]    = wr_cell && (held_r == CW'(i));

    if (i == DEPTH - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_mid
      assign next_entry = entry_vec[i+1];
    end

    if (i == 0) begin : g_first
      assign hole_in = 1'b0;
    end else begin : g_rest
      assign hole_in = hole_vec[i-1];
    end

    bst_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .valid_i      (valid_vec[i]),
      .wr_en_i      (wr_vec[i]),
      .key_i        (key_r),
      .next_entry_i (next_entry),
      .hole_i       (hole_in),
      .entry_o      (entry_vec[i]),
      .hole_o       (hole_vec[i]),
      .match_o      (match_vec[i])
    );
  end

  // The count is reported masked to its five bits.
  assign count_wide = (CW + CountWidth)'(held_r);

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_found  = out_found_r;
  assign out_count  = count_wide[CountWidth-1:0];

endmodule

FILE: hdl/bst_cell.sv
`timescale 1ns / 1ps
// One cell of the set table: holds one key, compares it with the broadcast key
// and takes its upper neighbour's key while a removal hole passes. Uses bst_pkg.
module bst_cell #(
  parameter int KEY_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bst_pkg::cell_ctrl_t    ctrl,
  input  logic                   valid_i,
  input  logic                   wr_en_i,
  input  logic [KEY_WIDTH-1:0]   key_i,
  input  logic [KEY_WIDTH-1:0]   next_entry_i,
  input  logic                   hole_i,
  output logic [KEY_WIDTH-1:0]   entry_o,
  output logic                   hole_o,
  output logic                   match_o
);
  import bst_pkg::*;

  logic [KEY_WIDTH-1:0] entry_r;
  logic                 hole_r;
  logic                 match_r;

  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      entry_r <= key_i;
    end else if (ctrl.step && hole_r) begin
      entry_r <= next_entry_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hole_r  <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (ctrl.cmp_en) begin
        match_r <= valid_i && (entry_r == key_i);
      end
      // The hole moves up one cell per step.
      if (ctrl.set_hole) begin
        hole_r <= match_r;
      end else if (ctrl.step) begin
        hole_r <= hole_i;
      end
    end
  end

  assign entry_o = entry_r;
  assign hole_o  = hole_r;
  assign match_o = match_r;

endmodule
